>>> hw/rtl/btgr_pkg.sv
// Shared constants, types and helpers for the bitmap text glyph renderer.
// No dependencies; imported by every module of the block.
package btgr_pkg;

  localparam int GLYPH_W      = 8;
  localparam int GLYPH_H      = 8;
  localparam int FIRST_CODE   = 32;
  localparam int CODE_COUNT   = 96;
  // power of two; row addresses wrap by masking
  localparam int FONT_DEPTH   = 1024;
  localparam int HEADER_WORDS = 4;
  localparam int NEWLINE_CODE = 10;

  localparam int ADDR_W = $clog2(FONT_DEPTH);
  localparam int COL_W  = $clog2(GLYPH_W);
  localparam int ROW_W  = $clog2(GLYPH_H);

  // cursor datapath: 16-bit coordinates, 18-bit signed limit compare
  localparam int CUR_W = 16;
  localparam int LIM_W = 18;
  localparam int CNT_W = $clog2(LIM_W);
  localparam int ADD_W = 9;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_DRAW  = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    REG_BOX_X      = 3'd0,
    REG_BOX_Y      = 3'd1,
    REG_BOX_W      = 3'd2,
    REG_MARGIN     = 3'd3,
    REG_CHAR_SPACE = 3'd4,
    REG_LINE_SPACE = 3'd5,
    REG_COLOR_FG   = 3'd6,
    REG_COLOR_BG   = 3'd7
  } reg_idx_e;

  typedef logic [ADDR_W-1:0] font_addr_t;

  typedef struct packed {
    logic       en;
    font_addr_t addr;
  } font_rd_t;

  typedef struct packed {
    logic             start;
    logic             is_start;
    logic             newline;
    logic [CUR_W-1:0] bx;
    logic [CUR_W-1:0] bw;
    logic [7:0]       mg;
    logic [CUR_W-1:0] cx;
    logic [CUR_W-1:0] cy;
    logic [ADD_W-1:0] xadd;
    logic [ADD_W-1:0] yadd;
  } cur_req_t;

  typedef struct packed {
    logic             busy;
    logic [CUR_W-1:0] x;
    logic [CUR_W-1:0] y;
  } cur_res_t;

  function automatic logic code_drawn(logic [7:0] code);
    int c;
    c = int'(code);
    return (c > FIRST_CODE) && (c < FIRST_CODE + CODE_COUNT);
  endfunction

  function automatic font_addr_t glyph_base(logic [7:0] code);
    logic [31:0] t;
    t = 32'((int'(code) - FIRST_CODE) * GLYPH_H + HEADER_WORDS);
    return t[ADDR_W-1:0];
  endfunction

endpackage

>>> hw/rtl/btgr_font_ram.sv
// Font store: single write port, single registered read port.
// Depends on btgr_pkg.
module btgr_font_ram (
  input  logic                clk_i,
  input  logic                we_i,
  input  btgr_pkg::font_addr_t waddr_i,
  input  logic [7:0]          wdata_i,
  input  btgr_pkg::font_rd_t  rd_i,
  output logic [7:0]          rdata_o
);
  import btgr_pkg::*;

  logic [7:0] mem_q [FONT_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/btgr_cursor.sv
// Bit-serial cursor update: sums, wrap limit and compare, LSB first, one bit a cycle.
// Depends on btgr_pkg.
module btgr_cursor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  btgr_pkg::cur_req_t req_i,
  output btgr_pkg::cur_res_t res_o
);
  import btgr_pkg::*;

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic             is_start_q, nl_q, sel_q;
  logic [CUR_W-1:0] bx_q, bw_q, cx_q, cy_q, ycur_q;
  logic [7:0]       mg_q;
  logic [ADD_W-1:0] xadd_q, yadd_q;
  logic [1:0]       csum_q, clim_q;
  logic             cdiff_q, cwrap_q, cyc_q;
  logic [CUR_W-1:0] sum_q, wrap_q, ysum_q;

  logic [2:0] t_sum, t_lim;
  logic [1:0] t_diff, t_wrap, t_y;
  logic       s_bit;

  always_comb begin
    // new x = cursor + (newline ? box_w : 0) + glyph width + spacing
    t_sum  = {2'b0, cx_q[0]} + {2'b0, nl_q & bw_q[0]} + {2'b0, xadd_q[0]} + {1'b0, csum_q};
    s_bit  = t_sum[0] & (cnt_q < CNT_W'(CUR_W));
    // limit = box_x + box_w - margin, exact
    t_lim  = {2'b0, bx_q[0]} + {2'b0, bw_q[0]} + {2'b0, ~mg_q[0]} + {1'b0, clim_q};
    // limit - new x; sign bit set means past the right edge
    t_diff = {1'b0, t_lim[0]} + {1'b0, ~s_bit} + {1'b0, cdiff_q};
    t_wrap = {1'b0, bx_q[0]} + {1'b0, mg_q[0]} + {1'b0, cwrap_q};
    t_y    = {1'b0, cy_q[0]} + {1'b0, yadd_q[0]} + {1'b0, cyc_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      sel_q  <= 1'b0;
    end else if (!busy_q) begin
      if (req_i.start) begin
        busy_q     <= 1'b1;
        cnt_q      <= '0;
        is_start_q <= req_i.is_start;
        nl_q       <= req_i.newline;
        bx_q       <= req_i.bx;
        bw_q       <= req_i.bw;
        mg_q       <= req_i.mg;
        cx_q       <= req_i.cx;
        cy_q       <= req_i.cy;
        ycur_q     <= req_i.cy;
        xadd_q     <= req_i.xadd;
        yadd_q     <= req_i.yadd;
        csum_q     <= 2'd0;
        clim_q     <= 2'd1;
        cdiff_q    <= 1'b1;
        cwrap_q    <= 1'b0;
        cyc_q      <= 1'b0;
      end
    end else begin
      bx_q    <= bx_q >> 1;
      bw_q    <= bw_q >> 1;
      mg_q    <= mg_q >> 1;
      cx_q    <= cx_q >> 1;
      cy_q    <= cy_q >> 1;
      xadd_q  <= xadd_q >> 1;
      yadd_q  <= yadd_q >> 1;
      csum_q  <= t_sum[2:1];
      clim_q  <= t_lim[2:1];
      cdiff_q <= t_diff[1];
      cwrap_q <= t_wrap[1];
      cyc_q   <= t_y[1];
      if (cnt_q < CNT_W'(CUR_W)) begin
        sum_q  <= {t_sum[0], sum_q[CUR_W-1:1]};
        wrap_q <= {t_wrap[0], wrap_q[CUR_W-1:1]};
        ysum_q <= {t_y[0], ysum_q[CUR_W-1:1]};
      end
      if (cnt_q == CNT_W'(LIM_W - 1)) begin
        busy_q <= 1'b0;
        sel_q  <= is_start_q | t_diff[0];
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign res_o.busy = busy_q;
  assign res_o.x    = sel_q ? wrap_q : sum_q;
  assign res_o.y    = sel_q ? ysum_q : ycur_q;

endmodule

>>> hw/rtl/btgr_glyph.sv
// Glyph serializer: fetches glyph rows, shifts out one pixel per cycle when not stalled.
// Depends on btgr_pkg; drives the read port of btgr_font_ram.
module btgr_glyph (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  btgr_pkg::font_addr_t base_i,
  output btgr_pkg::font_rd_t   rd_o,
  input  logic [7:0]           rdata_i,
  output logic                 busy_o,
  output logic                 pix_valid_o,
  input  logic                 pix_ready_i,
  output logic                 pix_set_o,
  output logic                 pix_last_o
);
  import btgr_pkg::*;

  typedef enum logic [1:0] {G_IDLE, G_PRIME, G_RUN, G_DRAIN} g_state_e;

  g_state_e         state_q;
  font_addr_t       base_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [7:0]       shreg_q;
  logic             ov_q, set_q, last_q;

  logic             emit, col_last, row_last;
  logic [ROW_W:0]   fetch_row;

  always_comb begin
    emit      = (state_q == G_RUN) && (!ov_q || pix_ready_i);
    col_last  = (col_q == COL_W'(GLYPH_W - 1));
    row_last  = (row_q == ROW_W'(GLYPH_H - 1));
    fetch_row = (state_q == G_PRIME) ? (ROW_W+1)'(1) : {1'b0, row_q} + (ROW_W+1)'(2);
    rd_o.en   = 1'b0;
    rd_o.addr = base_q + ADDR_W'(fetch_row);
    unique case (state_q)
      G_IDLE: begin
        rd_o.en   = start_i;
        rd_o.addr = base_i;
      end
      G_PRIME: rd_o.en = 1'b1;
      // next row is prefetched while the current one shifts out
      G_RUN:   rd_o.en = emit && col_last && (fetch_row < (ROW_W+1)'(GLYPH_H));
      default: rd_o.en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      ov_q    <= 1'b0;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      if (emit) begin
        ov_q <= 1'b1;
      end else if (pix_ready_i) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        G_IDLE: begin
          if (start_i) begin
            base_q  <= base_i;
            state_q <= G_PRIME;
          end
        end
        G_PRIME: begin
          shreg_q <= rdata_i;
          row_q   <= '0;
          col_q   <= '0;
          state_q <= G_RUN;
        end
        G_RUN: begin
          if (emit) begin
            set_q  <= shreg_q[7];
            last_q <= col_last && row_last;
            if (col_last) begin
              col_q <= '0;
              if (row_last) begin
                state_q <= G_DRAIN;
              end else begin
                row_q   <= row_q + 1'b1;
                shreg_q <= rdata_i;
              end
            end else begin
              col_q   <= col_q + 1'b1;
              shreg_q <= shreg_q << 1;
            end
          end
        end
        G_DRAIN: begin
          if (ov_q && pix_ready_i) begin
            state_q <= G_IDLE;
          end
        end
        default: state_q <= G_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != G_IDLE);
  assign pix_valid_o = ov_q;
  assign pix_set_o   = set_q;
  assign pix_last_o  = last_q;

endmodule

>>> hw/rtl/bitmap_text_glyph_renderer.sv
// Top level of the bitmap text glyph renderer: config registers, cursor, control.
// Depends on btgr_pkg, btgr_font_ram, btgr_cursor, btgr_glyph.
//
//  channel  handshake              payload
//  cfg      cfg_we_i               cfg_idx_i, cfg_data_i
//  in       in_valid_i/in_ready_o  opcode_i, font_addr_i, font_word_i, char_code_i
//  out      out_valid_o/out_ready_i char_x_o, char_y_o, pixel_color_o, last_pixel_o
//
// One request at a time. A load writes the font store when accepted and leaves
// the block idle. Start and characters that draw nothing are paced by the
// bit-serial cursor unit (18 bit steps). A drawn glyph leaves the serializer
// one pixel a cycle unless output stalls; the cursor update runs alongside.
// Reset clears state and sets config defaults; the font store is not cleared.
module bitmap_text_glyph_renderer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [9:0]  font_addr_i,
  input  logic [7:0]  font_word_i,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] char_x_o,
  output logic [15:0] char_y_o,
  output logic [15:0] pixel_color_o,
  output logic        last_pixel_o
);
  import btgr_pkg::*;

  typedef enum logic {ST_IDLE, ST_BUSY} t_state_e;

  t_state_e         state_q;
  logic [CUR_W-1:0] box_x_q, box_y_q, box_w_q, color_fg_q, color_bg_q;
  logic [7:0]       margin_q, char_space_q, line_space_q;
  logic [CUR_W-1:0] cursor_x_q, cursor_y_q;

  logic       accept, is_load, is_start, is_draw, mem_we, glyph_start;
  logic       glyph_busy, pix_set;
  logic [7:0] rdata;
  font_rd_t   rd;
  cur_req_t   cur_req;
  cur_res_t   cur_res;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    is_load  = 1'b0;
    is_start = 1'b0;
    is_draw  = 1'b0;
    unique case (opcode_e'(opcode_i))
      OP_LOAD:  is_load  = 1'b1;
      OP_START: is_start = 1'b1;
      OP_DRAW:  is_draw  = 1'b1;
      default: ;
    endcase
  end

  assign mem_we      = accept && is_load && ({1'b0, font_addr_i} < 11'(FONT_DEPTH));
  assign glyph_start = accept && is_draw && code_drawn(char_code_i);

  always_comb begin
    cur_req.start    = accept && (is_start || is_draw);
    cur_req.is_start = is_start;
    cur_req.newline  = (char_code_i == 8'(NEWLINE_CODE));
    cur_req.bx       = box_x_q;
    cur_req.bw       = box_w_q;
    cur_req.mg       = margin_q;
    cur_req.cx       = cursor_x_q;
    // a start reuses the y adder for box_y + margin
    cur_req.cy       = is_start ? box_y_q : cursor_y_q;
    cur_req.xadd     = ADD_W'(GLYPH_W) + {1'b0, char_space_q};
    cur_req.yadd     = is_start ? {1'b0, margin_q} : ADD_W'(GLYPH_H) + {1'b0, line_space_q};
  end

  btgr_font_ram u_font_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (font_addr_i[ADDR_W-1:0]),
    .wdata_i (font_word_i),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  btgr_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cur_req),
    .res_o  (cur_res)
  );

  btgr_glyph u_glyph (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (glyph_start),
    .base_i      (glyph_base(char_code_i)),
    .rd_o        (rd),
    .rdata_i     (rdata),
    .busy_o      (glyph_busy),
    .pix_valid_o (out_valid_o),
    .pix_ready_i (out_ready_i),
    .pix_set_o   (pix_set),
    .pix_last_o  (last_pixel_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q      <= '0;
      box_y_q      <= '0;
      box_w_q      <= 16'd240;
      margin_q     <= '0;
      char_space_q <= 8'd1;
      line_space_q <= 8'd1;
      color_fg_q   <= 16'hFFFF;
      color_bg_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_BOX_X:      box_x_q      <= cfg_data_i;
        REG_BOX_Y:      box_y_q      <= cfg_data_i;
        REG_BOX_W:      box_w_q      <= cfg_data_i;
        REG_MARGIN:     margin_q     <= cfg_data_i[7:0];
        REG_CHAR_SPACE: char_space_q <= cfg_data_i[7:0];
        REG_LINE_SPACE: line_space_q <= cfg_data_i[7:0];
        REG_COLOR_FG:   color_fg_q   <= cfg_data_i;
        REG_COLOR_BG:   color_bg_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // cursor is committed only after the last pixel has left, so pixels carry the old one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cursor_x_q <= '0;
      cursor_y_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cur_req.start) begin
            state_q <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (!glyph_busy && !cur_res.busy) begin
            cursor_x_q <= cur_res.x;
            cursor_y_q <= cur_res.y;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign char_x_o      = cursor_x_q;
  assign char_y_o      = cursor_y_q;
  assign pixel_color_o = pix_set ? color_fg_q : color_bg_q;

endmodule
